// ===== rtl/ctdnl_pkg.sv =====
// shared types, codes and note table for the clock tempo detector
`default_nettype none
package ctdnl_pkg;

   localparam int NOTE_COUNT = 16;
   localparam int NOTE_IDX_W = 4;
   localparam int TICK_W     = 20;
   localparam int DIV_N_W    = 29;
   localparam int DIV_D_W    = 21;
   localparam int DIV_CNT_W  = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 19;

   localparam logic [TICK_W-1:0] TICK_MAX = 20'hFFFFF;
   localparam logic [22:0]       US_MAX   = 23'h7FFFFF;
   localparam logic [17:0]       MHZ_MAX  = 18'h3FFFF;
   localparam logic [9:0]        BPM_OOR  = 10'd999;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_RATE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TRIGGER_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TRIGGER_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LOCK_TOL     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LIGHT        = 3'd5;

   // tempo status codes
   localparam logic [1:0] STATUS_NO_LOCK = 2'd0;
   localparam logic [1:0] STATUS_VALID   = 2'd1;
   localparam logic [1:0] STATUS_OOR     = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDGE,
      ST_BPM_START,
      ST_BPM_WAIT,
      ST_FINISH,
      ST_PREP,
      ST_US_WAIT,
      ST_MHZ_WAIT,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic capture;
      logic edge_step;
      logic start_bpm;
      logic finish;
      logic start_us;
      logic start_mhz;
      logic store_us;
      logic store_mhz;
      logic load_blank;
      logic next_note;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic emit;
      logic last_note;
   } sts_type;

   // note length as num/den beats
   function automatic logic [2:0] note_num(input logic [NOTE_IDX_W-1:0] k);
      case (k)
         4'd0:    note_num = 3'd4;
         4'd1:    note_num = 3'd3;
         4'd2:    note_num = 3'd2;
         4'd3:    note_num = 3'd4;
         4'd4:    note_num = 3'd3;
         4'd7:    note_num = 3'd3;
         4'd10:   note_num = 3'd3;
         4'd13:   note_num = 3'd3;
         4'd6:    note_num = 3'd2;
         default: note_num = 3'd1;
      endcase
   endfunction

   function automatic logic [4:0] note_den(input logic [NOTE_IDX_W-1:0] k);
      case (k)
         4'd0:    note_den = 5'd1;
         4'd1:    note_den = 5'd1;
         4'd2:    note_den = 5'd1;
         4'd3:    note_den = 5'd3;
         4'd4:    note_den = 5'd2;
         4'd5:    note_den = 5'd1;
         4'd6:    note_den = 5'd3;
         4'd7:    note_den = 5'd4;
         4'd8:    note_den = 5'd2;
         4'd9:    note_den = 5'd3;
         4'd10:   note_den = 5'd8;
         4'd11:   note_den = 5'd4;
         4'd12:   note_den = 5'd6;
         4'd13:   note_den = 5'd16;
         4'd14:   note_den = 5'd8;
         default: note_den = 5'd12;
      endcase
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ctdnl_ctrl.sv =====
// sequencing state machine for the clock tempo detector
`default_nettype none
module ctdnl_ctrl
   import ctdnl_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  wire     rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EDGE;
            end
         end
         ST_EDGE: begin
            cmd.edge_step = 1'b1;
            state_in      = ST_BPM_START;
         end
         ST_BPM_START: begin
            cmd.start_bpm = 1'b1;
            state_in      = ST_BPM_WAIT;
         end
         ST_BPM_WAIT: begin
            if (sts.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_PREP;
         end
         ST_PREP: begin
            if (sts.emit) begin
               cmd.start_us = 1'b1;
               state_in     = ST_US_WAIT;
            end else begin
               cmd.load_blank = 1'b1;
               state_in       = ST_SEND;
            end
         end
         ST_US_WAIT: begin
            if (sts.div_done) begin
               cmd.store_us  = 1'b1;
               cmd.start_mhz = 1'b1;
               state_in      = ST_MHZ_WAIT;
            end
         end
         ST_MHZ_WAIT: begin
            if (sts.div_done) begin
               cmd.store_mhz = 1'b1;
               state_in      = ST_SEND;
            end
         end
         ST_SEND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (sts.emit && !sts.last_note) begin
                  // step the note index first, the next division reads it
                  cmd.next_note = 1'b1;
                  state_in      = ST_PREP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/ctdnl_datapath.sv =====
// tempo state, shared divider, config registers and result register
`default_nettype none
module ctdnl_datapath
   import ctdnl_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire  [31:0]           req_tdata,
   input  wire                   csr_valid,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0] csr_data,
   input  cmd_type               cmd,
   output sts_type               sts,
   output logic [63:0]           rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   // configuration
   logic [17:0]        sample_rate_ff;
   logic signed [14:0] trig_high_mv_ff, trig_low_mv_ff;
   logic [9:0]         lock_tol_ff;
   logic [18:0]        timeout_ff;
   logic [14:0]        light_ticks_ff;

   // captured input
   logic               present_ff;
   logic signed [14:0] mv_ff;
   logic [14:0]        knob_ff;

   // tempo state
   logic              trig_ff, held_ff, lock_ff;
   logic [1:0]        edge_cnt_ff;
   logic [TICK_W-1:0] ticks_ff, ref_ff;
   logic [9:0]        prev_bpm_ff, bpm_ff;
   logic [14:0]       light_rem_ff;
   logic [1:0]        status_ff;
   logic              light_ff, emit_ff;

   // divider
   logic [DIV_D_W-1:0]   rem_ff, den_ff;
   logic [DIV_N_W-1:0]   quo_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff, done_ff;

   // result
   logic [NOTE_IDX_W-1:0] k_ff, idx_ff;
   logic [22:0]           us_ff;
   logic [17:0]           mhz_ff;
   logic                  nvalid_ff, last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_rate_ff  <= 18'd48000;
         trig_high_mv_ff <= 15'sd1000;
         trig_low_mv_ff  <= 15'sd0;
         lock_tol_ff     <= 10'd24;
         timeout_ff      <= 19'd96000;
         light_ticks_ff  <= 15'd4800;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SAMPLE_RATE:  sample_rate_ff  <= csr_data[17:0];
            REG_TRIGGER_HIGH: trig_high_mv_ff <= signed'(csr_data[14:0]);
            REG_TRIGGER_LOW:  trig_low_mv_ff  <= signed'(csr_data[14:0]);
            REG_LOCK_TOL:     lock_tol_ff     <= csr_data[9:0];
            REG_TIMEOUT:      timeout_ff      <= csr_data[18:0];
            REG_LIGHT:        light_ticks_ff  <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         present_ff <= req_tdata[0];
         mv_ff      <= signed'(req_tdata[15:1]);
         knob_ff    <= req_tdata[30:16];
      end
   end

   // edge step
   logic              rise, trig_e, held_e, lock_e;
   logic [1:0]        cnt_e, status_e;
   logic [TICK_W-1:0] ticks_e, ref_e, diff;
   logic [14:0]       light_e;
   logic              low_hit;

   always_comb begin
      low_hit  = mv_ff <= trig_low_mv_ff;
      rise     = 1'b0;
      trig_e   = trig_ff;
      held_e   = held_ff;
      lock_e   = lock_ff;
      cnt_e    = edge_cnt_ff;
      status_e = status_ff;
      ticks_e  = ticks_ff;
      ref_e    = ref_ff;
      light_e  = light_rem_ff;
      diff     = (ref_ff > ticks_ff) ? ref_ff - ticks_ff : ticks_ff - ref_ff;
      if (trig_ff) begin
         if (low_hit) begin
            trig_e = 1'b0;
         end
      end else if (mv_ff >= trig_high_mv_ff) begin
         trig_e = 1'b1;
         rise   = 1'b1;
      end
      if (rise && !held_ff) begin
         if (edge_cnt_ff != 2'd3) begin
            cnt_e = edge_cnt_ff + 2'd1;
         end
         if (!lock_ff) begin
            light_e = light_ticks_ff;
         end
         held_e = 1'b1;
         if (cnt_e == 2'd2) begin
            lock_e = 1'b1;
            ref_e  = ticks_ff;
         end else if (cnt_e == 2'd3 && diff > {10'd0, lock_tol_ff}) begin
            lock_e   = 1'b0;
            cnt_e    = 2'd0;
            status_e = STATUS_NO_LOCK;
         end
         ticks_e = '0;
      end
      if (low_hit && held_e) begin
         held_e = 1'b0;
      end
   end

   // finishing step
   logic [15:0]       knob_c;
   logic [28:0]       knob_prod;
   logic [TICK_W-1:0] ticks_f;
   logic [9:0]        bpm_f;
   logic              emit_f, lock_f;
   logic [1:0]        cnt_f, status_f;

   always_comb begin
      knob_c    = (knob_ff < 15'd3000) ? 16'd3050 : {1'b0, knob_ff} + 16'd50;
      // divide by 100 as times 5243 / 2^19, exact over the whole knob range
      knob_prod = {13'd0, knob_c} * 29'd5243;
      ticks_f   = ticks_ff;
      bpm_f     = '0;
      emit_f    = 1'b0;
      lock_f    = lock_ff;
      cnt_f     = edge_cnt_ff;
      status_f  = status_ff;
      if (present_ff) begin
         if (lock_ff) begin
            if (ref_ff != '0 && quo_ff < {19'd0, BPM_OOR}) begin
               status_f = STATUS_VALID;
               bpm_f    = quo_ff[9:0];
               emit_f   = bpm_f != prev_bpm_ff;
            end else begin
               status_f = STATUS_OOR;
            end
         end
         if (ticks_ff != TICK_MAX) begin
            ticks_f = ticks_ff + 1'b1;
         end
         if (ticks_f > {1'b0, timeout_ff}) begin
            lock_f   = 1'b0;
            cnt_f    = 2'd0;
            status_f = STATUS_NO_LOCK;
         end
      end else begin
         lock_f   = 1'b0;
         cnt_f    = 2'd0;
         status_f = STATUS_VALID;
         bpm_f    = knob_prod[28:19];
         emit_f   = bpm_f != prev_bpm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff      <= 1'b0;
         held_ff      <= 1'b0;
         lock_ff      <= 1'b0;
         edge_cnt_ff  <= 2'd0;
         ticks_ff     <= '0;
         ref_ff       <= '0;
         prev_bpm_ff  <= '0;
         light_rem_ff <= '0;
         status_ff    <= STATUS_NO_LOCK;
         emit_ff      <= 1'b0;
         light_ff     <= 1'b0;
      end else if (cmd.edge_step) begin
         if (present_ff) begin
            trig_ff      <= trig_e;
            held_ff      <= held_e;
            lock_ff      <= lock_e;
            edge_cnt_ff  <= cnt_e;
            status_ff    <= status_e;
            ticks_ff     <= ticks_e;
            ref_ff       <= ref_e;
            light_rem_ff <= light_e;
         end
      end else if (cmd.finish) begin
         lock_ff     <= lock_f;
         edge_cnt_ff <= cnt_f;
         status_ff   <= status_f;
         ticks_ff    <= ticks_f;
         emit_ff     <= emit_f;
         bpm_ff      <= bpm_f;
         if (emit_f) begin
            prev_bpm_ff <= bpm_f;
         end
         light_ff <= light_rem_ff != '0;
         if (light_rem_ff != '0) begin
            light_rem_ff <= light_rem_ff - 1'b1;
         end
      end
   end

   // divider operands
   logic [2:0]         num_k;
   logic [4:0]         den_k;
   logic [DIV_N_W-1:0] div_n;
   logic [DIV_D_W-1:0] div_d;
   logic [24:0]        sr120;
   logic [14:0]        bpm_den;
   logic               div_go;

   always_comb begin
      num_k   = note_num(k_ff);
      den_k   = note_den(k_ff);
      sr120   = {7'd0, sample_rate_ff} * 25'd120;
      bpm_den = {5'd0, bpm_ff} * {10'd0, den_k};
      div_go  = cmd.start_bpm | cmd.start_us | cmd.start_mhz;
      if (cmd.start_bpm) begin
         // quotient only used while a clock is present
         div_n = {3'd0, {1'b0, sr120} + {6'd0, ref_ff}};
         div_d = {ref_ff, 1'b0};
      end else if (cmd.start_us) begin
         div_n = {26'd0, num_k} * 29'd120000000 + {14'd0, bpm_den};
         div_d = {5'd0, bpm_den, 1'b0};
      end else begin
         div_n = {14'd0, bpm_den} * 29'd100 + {26'd0, num_k} * 29'd3;
         div_d = {18'd0, num_k} * 21'd6;
      end
   end

   // restoring divider, one quotient bit per cycle
   logic [DIV_D_W:0] trial;
   logic             fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DIV_N_W-1]};
      fits  = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_N_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_go) begin
         rem_ff <= '0;
         quo_ff <= div_n;
         den_ff <= div_d;
      end else if (busy_ff) begin
         rem_ff <= fits ? DIV_D_W'(trial - {1'b0, den_ff}) : trial[DIV_D_W-1:0];
         quo_ff <= {quo_ff[DIV_N_W-2:0], fits};
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         k_ff <= '0;
      end else if (cmd.next_note) begin
         k_ff <= k_ff + 1'b1;
      end
      if (cmd.load_blank) begin
         nvalid_ff <= 1'b0;
         idx_ff    <= '0;
         us_ff     <= '0;
         mhz_ff    <= '0;
         last_ff   <= 1'b1;
      end
      if (cmd.store_us) begin
         if (bpm_ff == '0 || quo_ff > {6'd0, US_MAX}) begin
            us_ff <= US_MAX;
         end else begin
            us_ff <= quo_ff[22:0];
         end
      end
      if (cmd.store_mhz) begin
         mhz_ff    <= (quo_ff > {11'd0, MHZ_MAX}) ? MHZ_MAX : quo_ff[17:0];
         nvalid_ff <= 1'b1;
         idx_ff    <= k_ff;
         last_ff   <= k_ff == NOTE_IDX_W'(NOTE_COUNT - 1);
      end
   end

   assign sts.div_done  = done_ff;
   assign sts.emit      = emit_ff;
   assign sts.last_note = k_ff == NOTE_IDX_W'(NOTE_COUNT - 1);

   assign rsp_tdata = {5'd0, light_ff, lock_ff | ~present_ff, status_ff, prev_bpm_ff,
                       mhz_ff, us_ff, idx_ff};
   assign rsp_tuser = nvalid_ff;
   assign rsp_tlast = last_ff;

endmodule
`default_nettype wire

// ===== rtl/clock_tempo_detector_note_lengths_top.sv =====
// top level of the clock tempo detector with note length table
//
// one req beat is one sample tick of the clock input plus the tempo knob.
// each tick answers with rsp beats: one blank beat (tuser 0), or, when the
// bpm in effect changes, sixteen note beats (tuser 1) with tlast on the last.
// config registers are written over the csr channel, always ready, and the user
// must write them only while idle; the block does not enforce it. a tick runs a
// 29-step restoring divider for the bpm, then a blank beat is offered, and the
// next req beat can be taken in the cycle after it leaves. a table's first note
// beat follows two more divisions; each further note needs two more divisions,
// started after the previous note is taken.
// one tick is worked at a time: req_tready is high only when all beats of the
// previous tick are taken. rsp payload sits in a register and holds while
// rsp_tready is low; the block simply waits.
// reset clears lock, counters and light and sets config registers to their defaults.
`default_nettype none
module clock_tempo_detector_note_lengths_top
   import ctdnl_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   // req beat
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire  [31:0]           req_tdata,  // clock_present, clock_mv, knob_centibpm
   // rsp beat
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   // note_index, note_us, note_millihz, tempo_bpm, tempo_status, locked, beat_light
   output logic [63:0]           rsp_tdata,
   output logic                  rsp_tuser,  // note_valid
   output logic                  rsp_tlast,  // last
   // config write
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   // writes must only come while idle, which is not enforced, so always take them
   assign csr_ready = 1'b1;

   ctdnl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ctdnl_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule
`default_nettype wire
